// ===== design/scancode_set1_to_hid_key_map_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scancode translator
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_SET1_TO_HID_KEY_MAP_ASSERT_SVH
`define SCANCODE_SET1_TO_HID_KEY_MAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/sc1h_pkg.sv =====
// ----------------------------------------------------------------------------
// sc1h_pkg
// Types, codes and scancode tables shared by the translator modules.
// ----------------------------------------------------------------------------
package sc1h_pkg;

  localparam logic [1:0] REQ_KEY_EVENT   = 2'd0;
  localparam logic [1:0] REQ_FRAME_START = 2'd1;
  localparam logic [1:0] REQ_KEY_QUERY   = 2'd2;

  localparam logic [7:0] MOD_FIRST = 8'hE0;
  localparam logic [7:0] MOD_LAST  = 8'hE7;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_EVENT,
    KIND_FRAME,
    KIND_QUERY
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  usage;
    logic        rel;
    logic        is_mod;
  } q_entry_t;

  function automatic logic [7:0] plain_usage(input logic [6:0] sc);
    logic [7:0] u;
    case (sc)
      7'h01: u = 8'h29; 7'h02: u = 8'h1E; 7'h03: u = 8'h1F; 7'h04: u = 8'h20;
      7'h05: u = 8'h21; 7'h06: u = 8'h22; 7'h07: u = 8'h23; 7'h08: u = 8'h24;
      7'h09: u = 8'h25; 7'h0A: u = 8'h26; 7'h0B: u = 8'h27; 7'h0C: u = 8'h2D;
      7'h0D: u = 8'h2E; 7'h0E: u = 8'h2A; 7'h0F: u = 8'h2B; 7'h10: u = 8'h14;
      7'h11: u = 8'h1A; 7'h12: u = 8'h08; 7'h13: u = 8'h15; 7'h14: u = 8'h17;
      7'h15: u = 8'h1C; 7'h16: u = 8'h18; 7'h17: u = 8'h0C; 7'h18: u = 8'h12;
      7'h19: u = 8'h13; 7'h1A: u = 8'h2F; 7'h1B: u = 8'h30; 7'h1C: u = 8'h28;
      7'h1D: u = 8'hE0; 7'h1E: u = 8'h04; 7'h1F: u = 8'h16; 7'h20: u = 8'h07;
      7'h21: u = 8'h09; 7'h22: u = 8'h0A; 7'h23: u = 8'h0B; 7'h24: u = 8'h0D;
      7'h25: u = 8'h0E; 7'h26: u = 8'h0F; 7'h27: u = 8'h33; 7'h28: u = 8'h34;
      7'h29: u = 8'h35; 7'h2A: u = 8'hE1; 7'h2B: u = 8'h31; 7'h2C: u = 8'h1D;
      7'h2D: u = 8'h1B; 7'h2E: u = 8'h06; 7'h2F: u = 8'h19; 7'h30: u = 8'h05;
      7'h31: u = 8'h11; 7'h32: u = 8'h10; 7'h33: u = 8'h36; 7'h34: u = 8'h37;
      7'h35: u = 8'h38; 7'h36: u = 8'hE5; 7'h37: u = 8'h55; 7'h38: u = 8'hE2;
      7'h39: u = 8'h2C; 7'h3A: u = 8'h39; 7'h3B: u = 8'h3A; 7'h3C: u = 8'h3B;
      7'h3D: u = 8'h3C; 7'h3E: u = 8'h3D; 7'h3F: u = 8'h3E; 7'h40: u = 8'h3F;
      7'h41: u = 8'h40; 7'h42: u = 8'h41; 7'h43: u = 8'h42; 7'h44: u = 8'h43;
      7'h45: u = 8'h53; 7'h46: u = 8'h47; 7'h47: u = 8'h5F; 7'h48: u = 8'h60;
      7'h49: u = 8'h61; 7'h4A: u = 8'h56; 7'h4B: u = 8'h5C; 7'h4C: u = 8'h5D;
      7'h4D: u = 8'h5E; 7'h4E: u = 8'h57; 7'h4F: u = 8'h59; 7'h50: u = 8'h5A;
      7'h51: u = 8'h5B; 7'h52: u = 8'h62; 7'h53: u = 8'h63; 7'h57: u = 8'h44;
      7'h58: u = 8'h45;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

  function automatic logic [7:0] ext_usage(input logic [6:0] sc);
    logic [7:0] u;
    case (sc)
      7'h1C: u = 8'h58; 7'h1D: u = 8'hE4; 7'h35: u = 8'h54; 7'h38: u = 8'hE6;
      7'h47: u = 8'h4A; 7'h48: u = 8'h52; 7'h49: u = 8'h4B; 7'h4B: u = 8'h50;
      7'h4D: u = 8'h4F; 7'h4F: u = 8'h4D; 7'h50: u = 8'h51; 7'h51: u = 8'h4E;
      7'h52: u = 8'h49; 7'h53: u = 8'h4C; 7'h5B: u = 8'hE3; 7'h5C: u = 8'hE7;
      7'h5D: u = 8'h65;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

endpackage

// ===== design/sc1h_front.sv =====
// ----------------------------------------------------------------------------
// sc1h_front
// Takes requests, translates scancodes and classifies them for the queue.
// ----------------------------------------------------------------------------
module sc1h_front
  import sc1h_pkg::*;
(
  input  logic       start,
  input  logic       queue_full,
  input  logic [1:0] req_type,
  input  logic [6:0] scan_code,
  input  logic       extended_prefix,
  input  logic       is_release,
  input  logic [7:0] key_index,
  output logic       busy,
  output logic       push,
  output q_entry_t   push_data
);

  logic [7:0] mapped;

  assign busy = queue_full;
  assign push = start && !queue_full;
  assign mapped = extended_prefix ? ext_usage(scan_code) : plain_usage(scan_code);

  always_comb begin
    push_data        = '0;
    push_data.kind   = KIND_NONE;
    case (req_type)
      REQ_KEY_EVENT: begin
        if (mapped != 8'h00) begin
          push_data.kind   = KIND_EVENT;
          push_data.usage  = mapped;
          push_data.rel    = is_release;
          push_data.is_mod = mapped inside {[MOD_FIRST:MOD_LAST]};
        end
      end
      REQ_FRAME_START: begin
        push_data.kind = KIND_FRAME;
      end
      REQ_KEY_QUERY: begin
        push_data.kind  = KIND_QUERY;
        push_data.usage = key_index;
      end
      default: begin
        push_data.kind = KIND_NONE;
      end
    endcase
  end

endmodule

// ===== design/sc1h_queue.sv =====
// ----------------------------------------------------------------------------
// sc1h_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`include "scancode_set1_to_hid_key_map_assert.svh"

module sc1h_queue
  import sc1h_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t pop_data,
  output logic     full,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `ASSERT_IMPLIES(a_no_overflow, push, !full || pop)

endmodule

// ===== design/sc1h_back.sv =====
// ----------------------------------------------------------------------------
// sc1h_back
// Applies queued requests to the frame map and modifier byte, drives results.
// ----------------------------------------------------------------------------
`include "scancode_set1_to_hid_key_map_assert.svh"

module sc1h_back
  import sc1h_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       queue_empty,
  input  q_entry_t   entry,
  output logic       pop,
  output logic       done,
  output logic [7:0] hid_usage,
  output logic [7:0] key_down_usage_unused_guard,
  output logic       key_down,
  output logic [7:0] modifier_byte
);

  logic [255:0] frame_keys;
  logic [255:0] frame_keys_next;
  logic [7:0]   held_modifiers;
  logic [7:0]   held_modifiers_next;
  logic [7:0]   hid_usage_next;
  logic         key_down_next;
  logic [7:0]   mod_mask;

  assign pop           = !queue_empty;
  assign modifier_byte = held_modifiers;
  assign key_down_usage_unused_guard = hid_usage;
  assign mod_mask      = 8'(1) << entry.usage[2:0];

  always_comb begin
    frame_keys_next     = frame_keys;
    held_modifiers_next = held_modifiers;
    hid_usage_next      = 8'h00;
    key_down_next       = 1'b0;
    if (pop) begin
      case (entry.kind)
        KIND_EVENT: begin
          hid_usage_next = entry.usage;
          if (entry.is_mod) begin
            held_modifiers_next = entry.rel ? (held_modifiers & ~mod_mask)
                                            : (held_modifiers | mod_mask);
            frame_keys_next[entry.usage] = !entry.rel;
            key_down_next = !entry.rel;
          end else if (!entry.rel) begin
            frame_keys_next[entry.usage] = 1'b1;
            key_down_next = 1'b1;
          end else begin
            key_down_next = frame_keys[entry.usage];
          end
        end
        KIND_FRAME: begin
          frame_keys_next = '0;
          frame_keys_next[MOD_LAST:MOD_FIRST] = held_modifiers;
        end
        KIND_QUERY: begin
          key_down_next = frame_keys[entry.usage];
        end
        default: begin
          hid_usage_next = 8'h00;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_keys     <= '0;
      held_modifiers <= '0;
      done           <= 1'b0;
    end else begin
      frame_keys     <= frame_keys_next;
      held_modifiers <= held_modifiers_next;
      done           <= pop;
    end
  end

  always_ff @(posedge clk) begin
    hid_usage <= hid_usage_next;
    key_down  <= key_down_next;
  end

  // modifier frame bits always mirror the held byte
  `ASSERT_IMPLIES(a_mod_bits_track, 1'b1, frame_keys[MOD_LAST:MOD_FIRST] == held_modifiers)
  `ASSERT_NEXT(a_result_per_pop, pop, done)
  `ASSERT_NEXT(a_no_stray_result, !pop, !done)

endmodule

// ===== design/scancode_set1_to_hid_key_map.sv =====
// ----------------------------------------------------------------------------
// scancode_set1_to_hid_key_map
// Set-1 scancode to HID usage translator with a per-frame key map.
// ----------------------------------------------------------------------------
// Requests enter on start while busy is low: a key event (scan_code,
// extended_prefix, is_release), a frame start, or a key query (key_index).
// Every request gives exactly one result, shown for one cycle with done
// high: hid_usage, key_down and modifier_byte (held modifiers after it).
// The receiver cannot stall; results must be taken when done is high.
// The accepting edge writes the request queue; the back end then pops
// the entry and registers the result and done together from it.
// Throughput: one request per cycle; the back end drains an entry every cycle,
// so the queue holds at most one and busy stays low while QUEUE_DEPTH > 1.
// Reset (rst, synchronous) clears the 256-bit frame map, the held
// modifiers and the queue; requests are taken right after.
// ----------------------------------------------------------------------------
module scancode_set1_to_hid_key_map
  import sc1h_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic [6:0] scan_code,
  input  logic       extended_prefix,
  input  logic       is_release,
  input  logic [7:0] key_index,
  output logic       done,
  output logic [7:0] hid_usage,
  output logic       key_down,
  output logic [7:0] modifier_byte
);

  q_entry_t   push_data;
  q_entry_t   pop_data;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_empty;
  logic [7:0] usage_copy;

  sc1h_front u_front (
    .start           (start),
    .queue_full      (queue_full),
    .req_type        (req_type),
    .scan_code       (scan_code),
    .extended_prefix (extended_prefix),
    .is_release      (is_release),
    .key_index       (key_index),
    .busy            (busy),
    .push            (push),
    .push_data       (push_data)
  );

  sc1h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  sc1h_back u_back (
    .clk                         (clk),
    .rst                         (rst),
    .queue_empty                 (queue_empty),
    .entry                       (pop_data),
    .pop                         (pop),
    .done                        (done),
    .hid_usage                   (hid_usage),
    .key_down_usage_unused_guard (usage_copy),
    .key_down                    (key_down),
    .modifier_byte               (modifier_byte)
  );

  `include "scancode_set1_to_hid_key_map_assert.svh"

  `ASSERT_IMPLIES(a_usage_copy, done, usage_copy == hid_usage)

endmodule
